>>> hdl/bdkd_pkg.sv
// Package for the button debounce and knob direction unit.
// Holds the channel layout, command and register codes, and shared item types.
// No dependencies.
package bdkd_pkg;

  localparam int CHANNELS   = 3;
  localparam int CH_W       = 2;
  localparam int WORD_W     = 32;
  localparam int MS_W       = 16;
  localparam int POS_W      = 6;
  localparam int BTN_MSB    = 26;
  localparam int POS_LSB    = 18;
  localparam int POS_STRIDE = 8;
  localparam int WRAP_LIMIT = 32;
  localparam int IN_TDATA_W = 32;
  localparam int IN_TUSER_W = 4;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_W      = 16;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_PRESS_POLL = 2'd1,
    CMD_ROT_POLL   = 2'd2,
    CMD_ROT_RESYNC = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2
  } dir_e;

  typedef enum logic [0:0] {
    REG_DEBOUNCE = 1'b0,
    REG_REVERSE  = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e                command;
    logic [CH_W-1:0]     channel;
    logic [WORD_W-1:0]   knob_word;
  } item_t;

  typedef struct packed {
    logic press_edge;
    dir_e direction;
  } result_t;

  typedef struct packed {
    logic [MS_W-1:0] debounce_interval_ms;
    logic            reverse_rotation;
  } cfg_t;

endpackage

>>> hdl/bdkd_core.sv
// Per-channel debounce and rotation state with the result logic for one transaction.
// Depends on bdkd_pkg.
module bdkd_core import bdkd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [MS_W-1:0]  elapsed_q   [CHANNELS];
  logic [MS_W-1:0]  elapsed_d   [CHANNELS];
  logic             prev_smp_q  [CHANNELS];
  logic             prev_smp_d  [CHANNELS];
  logic             stable_q    [CHANNELS];
  logic             stable_d    [CHANNELS];
  logic             flag_q      [CHANNELS];
  logic             flag_d      [CHANNELS];
  logic [POS_W-1:0] prev_pos_q  [CHANNELS];
  logic [POS_W-1:0] prev_pos_d  [CHANNELS];

  always_comb begin
    logic             smp;
    logic             flag_n;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] mag;
    logic             up;
    result_o = '{press_edge: 1'b0, direction: DIR_NONE};
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed_d[i]  = elapsed_q[i];
      prev_smp_d[i] = prev_smp_q[i];
      stable_d[i]   = stable_q[i];
      flag_d[i]     = flag_q[i];
      prev_pos_d[i] = prev_pos_q[i];
      smp    = item_i.knob_word[BTN_MSB - i];
      pos    = item_i.knob_word[POS_LSB - POS_STRIDE * i +: POS_W];
      if (cfg_i.reverse_rotation) begin
        pos = ~pos;
      end
      up     = pos > prev_pos_q[i];
      mag    = up ? (pos - prev_pos_q[i]) : (prev_pos_q[i] - pos);
      flag_n = flag_q[i];
      if (fire_i) begin
        if (item_i.command == CMD_TICK) begin
          if (elapsed_q[i] != '1) begin
            elapsed_d[i] = elapsed_q[i] + MS_W'(1);
          end
        end else if (item_i.channel == CH_W'(i)) begin
          unique case (item_i.command)
            CMD_PRESS_POLL: begin
              if (elapsed_q[i] > cfg_i.debounce_interval_ms) begin
                if (smp == prev_smp_q[i]) begin
                  if (smp != stable_q[i]) begin
                    flag_n = stable_q[i] & ~smp;
                  end
                  stable_d[i] = smp;
                end
                prev_smp_d[i] = smp;
                elapsed_d[i]  = '0;
              end
              result_o.press_edge = flag_n;
              flag_d[i] = 1'b0;
            end
            CMD_ROT_POLL: begin
              prev_pos_d[i] = pos;
              if (pos != prev_pos_q[i]) begin
                if (mag > POS_W'(WRAP_LIMIT)) begin
                  up = ~up;
                end
                result_o.direction = up ? DIR_RIGHT : DIR_LEFT;
              end
            end
            CMD_ROT_RESYNC: begin
              prev_pos_d[i] = pos;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed_q[i]  <= '1;
        prev_smp_q[i] <= 1'b0;
        stable_q[i]   <= 1'b0;
        flag_q[i]     <= 1'b0;
        prev_pos_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed_q[i]  <= elapsed_d[i];
        prev_smp_q[i] <= prev_smp_d[i];
        stable_q[i]   <= stable_d[i];
        flag_q[i]     <= flag_d[i];
        prev_pos_q[i] <= prev_pos_d[i];
      end
    end
  end

endmodule

>>> hdl/button_debounce_and_knob_direction_unit.sv
// Top level of the button debounce and knob direction unit.
// Input register, configuration registers and result register around bdkd_core.
// Depends on bdkd_pkg and bdkd_core.
//
// The unit takes one transaction per clock cycle while the output is not stalled and
// returns exactly one result for each, in order: an item is held in the input register,
// then its result in the result register, with all per-channel state updated as an
// item moves from the first to the second. There is no clearing pass after reset.
// Configuration should be written only while the unit is idle.
module button_debounce_and_knob_direction_unit import bdkd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // knob_word[31:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // command[1:0], channel[3:2]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // press_edge[0], direction[2:1], zero[7:3]
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t res;
  cfg_t    cfg_q;
  logic    advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{debounce_interval_ms: MS_W'(50), reverse_rotation: 1'b0};
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_DEBOUNCE: cfg_q.debounce_interval_ms <= cfg_wdata_i[MS_W-1:0];
        REG_REVERSE:  cfg_q.reverse_rotation     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.command   <= cmd_e'(s_axis_tuser[1:0]);
      in_item_q.channel   <= s_axis_tuser[3:2];
      in_item_q.knob_word <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  bdkd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - 3)'(0), out_res_q.direction, out_res_q.press_edge};

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3))
    else $error("invalid direction code on result");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[2:1] != 2'd0)))
    else $error("press and direction reported by one result");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled output");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed item did not reach the result register");

endmodule

>>> bench/tb.sv
// Self-checking testbench for button_debounce_and_knob_direction_unit.
// A scoreboard class predicts debounce, press and rotation results per
// transaction; depends only on bdkd_pkg and the unit's RTL.
module tb;
  import bdkd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  class knob_scoreboard;
    logic [MS_W-1:0]  interval_ms;
    logic             reverse;
    logic [MS_W-1:0]  elapsed[CHANNELS];
    logic             last_sample[CHANNELS];
    logic             stable[CHANNELS];
    logic             pressed[CHANNELS];
    logic [POS_W-1:0] last_pos[CHANNELS];
    result_t          expected_q[$];
    int               mismatches;

    function new();
      interval_ms = MS_W'(50);
      reverse = 1'b0;
      mismatches = 0;
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed[i] = '1;
        last_sample[i] = 1'b0;
        stable[i] = 1'b0;
        pressed[i] = 1'b0;
        last_pos[i] = '0;
      end
    endfunction

    function void note_item(item_t it);
      result_t          r;
      int               ch;
      int               delta;
      int               mag;
      logic             btn;
      logic             up;
      logic [POS_W-1:0] pos;
      r = '0;
      r.direction = DIR_NONE;
      ch = int'(it.channel);
      if (it.command == CMD_TICK) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (elapsed[i] != '1) elapsed[i] = elapsed[i] + 1'b1;
        end
      end else if (ch < CHANNELS) begin
        btn = it.knob_word[BTN_MSB - ch];
        pos = POS_W'(it.knob_word >> (POS_LSB - POS_STRIDE * ch));
        if (reverse) pos = POS_MAX - pos;
        case (it.command)
          CMD_PRESS_POLL: begin
            if (elapsed[ch] > interval_ms) begin
              if (btn == last_sample[ch]) begin
                if (btn != stable[ch]) pressed[ch] = stable[ch] & ~btn;
                stable[ch] = btn;
              end
              last_sample[ch] = btn;
              elapsed[ch] = '0;
            end
            r.press_edge = pressed[ch];
            pressed[ch] = 1'b0;
          end
          CMD_ROT_POLL: begin
            delta = int'(pos) - int'(last_pos[ch]);
            last_pos[ch] = pos;
            if (delta != 0) begin
              up = (delta > 0);
              mag = up ? delta : -delta;
              if (mag > WRAP_LIMIT) up = ~up;
              r.direction = up ? DIR_RIGHT : DIR_LEFT;
            end
          end
          default: last_pos[ch] = pos;
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("result without pending expectation: press_edge %0b direction %0d",
                   got.press_edge, got.direction);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.press_edge !== exp_r.press_edge || got.direction !== exp_r.direction) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display({"mismatch: expected press_edge %0b direction %0d, ",
                    "got press_edge %0b direction %0d"},
                   exp_r.press_edge, exp_r.direction, got.press_edge, got.direction);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic                   cfg_addr_i;
  logic [CFG_W-1:0]       cfg_wdata_i;

  knob_scoreboard   sb;
  logic             tx_idle;
  logic             rx_stalls;
  logic             btn_level[CHANNELS];
  logic [POS_W-1:0] pos_level[CHANNELS];
  int               cycles;

  button_debounce_and_knob_direction_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    item_t   it;
    result_t got;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.command = cmd_e'(s_axis_tuser[1:0]);
        it.channel = s_axis_tuser[3:2];
        it.knob_word = s_axis_tdata;
        sb.note_item(it);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.press_edge = m_axis_tdata[0];
        got.direction = dir_e'(m_axis_tdata[2:1]);
        sb.check_result(got);
      end
    end
  end

  initial begin : receiver
    int n;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_stalls && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic logic [WORD_W-1:0] build_word(input logic [WORD_W-1:0] noise);
    logic [WORD_W-1:0] w;
    w = noise;
    for (int c = 0; c < CHANNELS; c++) begin
      w[BTN_MSB - c] = btn_level[c];
      w[POS_LSB - POS_STRIDE * c +: POS_W] = pos_level[c];
    end
    return w;
  endfunction

  task automatic send(input cmd_e cmd, input logic [CH_W-1:0] ch, input logic [WORD_W-1:0] w);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= {ch, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [MS_W-1:0] interval, input logic rev);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_DEBOUNCE;
    cfg_wdata_i <= interval;
    @(posedge clk_i);
    cfg_addr_i  <= REG_REVERSE;
    cfg_wdata_i <= CFG_W'(rev);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.interval_ms = interval;
    sb.reverse = rev;
  endtask

  task automatic send_random(input int tick_pct, input int flip_odds);
    int   r;
    cmd_e cmd;
    logic [CH_W-1:0] ch;
    for (int c = 0; c < CHANNELS; c++) begin
      if ($urandom_range(1, flip_odds) == 1) btn_level[c] = ~btn_level[c];
      r = $urandom_range(0, 9);
      if (r < 3) pos_level[c] = pos_level[c] + POS_W'($urandom_range(1, 4));
      else if (r < 6) pos_level[c] = pos_level[c] - POS_W'($urandom_range(1, 4));
      else if (r == 6) pos_level[c] = POS_W'($urandom());
    end
    r = $urandom_range(0, 99);
    if (r < tick_pct) cmd = CMD_TICK;
    else begin
      r = $urandom_range(0, 99);
      cmd = (r < 50) ? CMD_PRESS_POLL : (r < 85) ? CMD_ROT_POLL : CMD_ROT_RESYNC;
    end
    ch = ($urandom_range(0, 19) == 0) ? CH_W'(3) : CH_W'($urandom_range(0, CHANNELS - 1));
    send(cmd, ch, build_word($urandom()));
  endtask

  initial begin : stimulus
    int p_interval[6];
    int p_reverse[6];
    int p_count[6];
    int p_ticks[6];
    int p_flip[6];
    logic quiet;
    p_interval = '{0, 1, 3, 50, 65534, 2};
    p_reverse  = '{0, 1, 0, 1, 1, 0};
    p_count    = '{150, 150, 150, 120, 40, 140};
    p_ticks    = '{35, 45, 55, 85, 40, 45};
    p_flip     = '{10, 12, 16, 150, 10, 12};
    sb = new();
    tx_idle = 1'b0;
    rx_stalls = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      btn_level[c] = 1'b0;
      pos_level[c] = '0;
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= REG_DEBOUNCE;
    cfg_wdata_i   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: the counters start saturated, so the first polls sample.
    btn_level = '{1'b1, 1'b0, 1'b1};
    pos_level = '{6'd63, 6'd1, 6'd0};
    send(CMD_PRESS_POLL, 2'd0, build_word('0));
    send(CMD_PRESS_POLL, 2'd1, build_word('1));
    send(CMD_PRESS_POLL, 2'd2, build_word('0));
    send(CMD_ROT_POLL, 2'd0, build_word('1));
    send(CMD_ROT_POLL, 2'd1, build_word('0));
    send(CMD_ROT_POLL, 2'd2, build_word('1));
    pos_level[0] = 6'd10;
    send(CMD_ROT_RESYNC, 2'd0, build_word('0));
    pos_level[0] = 6'd9;
    send(CMD_ROT_POLL, 2'd0, build_word('0));
    pos_level[0] = 6'd41;
    send(CMD_ROT_POLL, 2'd0, build_word('1));
    pos_level[0] = 6'd8;
    send(CMD_ROT_POLL, 2'd0, build_word('0));
    send(CMD_PRESS_POLL, 2'd3, '1);
    send(CMD_ROT_POLL, 2'd3, '1);
    send(CMD_ROT_RESYNC, 2'd3, '0);
    send(CMD_TICK, 2'd3, '1);
    send(CMD_TICK, 2'd0, '0);
    drain();

    configure('0, 1'b1);
    send(CMD_TICK, 2'd0, build_word('0));
    send(CMD_PRESS_POLL, 2'd0, build_word('0));
    send(CMD_TICK, 2'd2, build_word('0));
    btn_level[0] = 1'b0;
    send(CMD_PRESS_POLL, 2'd0, build_word('1));
    send(CMD_TICK, 2'd1, build_word('0));
    send(CMD_PRESS_POLL, 2'd0, build_word('0));
    send(CMD_PRESS_POLL, 2'd0, build_word('0));
    pos_level[1] = 6'd0;
    send(CMD_ROT_POLL, 2'd1, build_word('1));
    pos_level[2] = 6'd63;
    send(CMD_ROT_RESYNC, 2'd2, build_word('0));

    for (int p = 0; p < 6; p++) begin
      drain();
      configure(MS_W'(p_interval[p]), p_reverse[p][0]);
      quiet = (p == 5);
      for (int k = 0; k < p_count[p]; k++) begin
        if (k % 50 == 0) begin
          tx_idle = !quiet && ($urandom_range(0, 2) != 0);
          rx_stalls = !quiet && ($urandom_range(0, 2) != 0);
        end
        send_random(p_ticks[p], p_flip[p]);
      end
    end
    drain();
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
